@@ rtl/mcfir_pkg.sv @@
// Shared types, constants and register codes of the multichannel FIR filter core.
`default_nettype none

package mcfir_pkg;

    localparam int CHANNELS   = 16;
    localparam int TAPS       = 7;
    localparam int NUM_COEF   = 7;

    localparam int CH_W       = 4;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int TAPCNT_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_IDX_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + $clog2(TAPS) + 1;
    localparam int HALF_TAPS  = (TAPS + 1) / 2;
    localparam int FRAC_W     = 15;
    localparam int Q_W        = ACC_W - FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    typedef sample_t [TAPS-1:0] hist_row_t;
    typedef prod_t   [TAPS-1:0] prod_vec_t;

    typedef struct packed {
        logic [CH_W-1:0] channel;
        sample_t         sample_in;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0] out_channel;
        sample_t         sample_out;
    } out_t;

    typedef struct packed {
        logic [TAPCNT_W-1:0]       tap_count;
        coef_t [NUM_COEF-1:0]      coef;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/multichannel_fir_filter_core.sv @@
// Top level of the multichannel FIR filter core: pipeline control and handshakes.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   input   | s_valid, s_ready, s_data (in_t)          | in
//   result  | m_valid, m_ready, m_data (out_t)         | out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// One beat per cycle sustained while m_ready does not hold back the result channel.
// Stages: input register, history update and tap multipliers, half sums, output register.
// Each stage holds only while the stage after it is full and blocked, so an input beat is
// taken while a result waits if a stage is empty. Reset clears valids, config and all history.
`default_nettype none

module multichannel_fir_filter_core import mcfir_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_t                   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_t                       m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic v0_next, v1_next, v2_next, v3_next;
    logic adv0, adv1, adv2, adv3;
    logic rdy1, rdy2, rdy3;

    in_t                 in_reg;
    logic [CH_W-1:0]     ch1_reg, ch2_reg;
    sample_t             x1_reg, x2_reg;
    logic                byp1_reg, byp2_reg;
    out_t                out_reg;

    logic [TAPCNT_W-1:0] n_taps;
    logic [CH_IDX_W-1:0] ch_idx;
    hist_row_t           old_row;
    prod_vec_t           prod;
    sample_t             result;

    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = !v0_reg || rdy1;

    assign adv0 = s_valid && s_ready;
    assign adv1 = v0_reg && rdy1;
    assign adv2 = v1_reg && rdy2;
    assign adv3 = v2_reg && rdy3;

    assign v0_next = adv0 || (v0_reg && !adv1);
    assign v1_next = adv1 || (v1_reg && !adv2);
    assign v2_next = adv2 || (v2_reg && !adv3);
    assign v3_next = adv3 || (v3_reg && !m_ready);

    assign m_valid = v3_reg;
    assign m_data  = out_reg;

    assign n_taps = (int'(cfg.tap_count) > TAPS) ? TAPCNT_W'(TAPS) : cfg.tap_count;
    assign ch_idx = CH_IDX_W'(in_reg.channel % CHANNELS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv0) begin
            in_reg <= s_data;
        end
        if (adv1) begin
            ch1_reg  <= in_reg.channel;
            x1_reg   <= in_reg.sample_in;
            byp1_reg <= (n_taps == '0);
        end
        if (adv2) begin
            ch2_reg  <= ch1_reg;
            x2_reg   <= x1_reg;
            byp2_reg <= byp1_reg;
        end
        if (adv3) begin
            out_reg.out_channel <= ch2_reg;
            out_reg.sample_out  <= result;
        end
    end

    mcfir_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcfir_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (adv1),
        .ch_idx  (ch_idx),
        .sample  (in_reg.sample_in),
        .rd_row  (old_row)
    );

    mcfir_lanes u_lanes (
        .aclk    (aclk),
        .en      (adv1),
        .sample  (in_reg.sample_in),
        .old_row (old_row),
        .n_taps  (n_taps),
        .cfg     (cfg),
        .prod    (prod)
    );

    mcfir_sum u_sum (
        .aclk          (aclk),
        .en            (adv2),
        .prod          (prod),
        .bypass        (byp2_reg),
        .bypass_sample (x2_reg),
        .result        (result)
    );

`ifndef SYNTH
    a_ready_when_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input blocked while output stage can drain");

    a_input_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v0_reg && !adv1) |=> (v0_reg && $stable(in_reg)))
        else $error("input stage lost or changed a blocked beat");

    a_bypass_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv3 && byp2_reg) |=> (m_data.sample_out == $past(x2_reg)))
        else $error("pass-through beat altered");
`endif

endmodule

`default_nettype wire

@@ rtl/mcfir_cfg.sv @@
// Configuration register file: tap count and coefficient registers.
`default_nettype none

module mcfir_cfg import mcfir_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_TAP_COUNT) begin
                cfg_reg.tap_count <= cfg_data[TAPCNT_W-1:0];
            end else begin
                cfg_reg.coef[CFG_IDX_W'(cfg_index - REG_COEF_0)] <= coef_t'(cfg_data);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/mcfir_hist.sv @@
// Per-channel sample history held in flops, cleared at reset.
`default_nettype none

module mcfir_hist import mcfir_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                wr_en,
    input  wire logic [CH_IDX_W-1:0] ch_idx,
    input  wire sample_t             sample,
    output hist_row_t                rd_row
);

    hist_row_t row_reg [CHANNELS];
    hist_row_t row_next;

    assign rd_row = row_reg[ch_idx];

    always_comb begin
        row_next[0] = sample;
        for (int j = 1; j < TAPS; j++) begin
            row_next[j] = rd_row[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                row_reg[c] <= '0;
            end
        end else if (wr_en) begin
            row_reg[ch_idx] <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mcfir_lanes.sv @@
// Tap lanes: window select and one registered multiplier per tap.
`default_nettype none

module mcfir_lanes import mcfir_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire sample_t             sample,
    input  wire hist_row_t           old_row,
    input  wire logic [TAPCNT_W-1:0] n_taps,
    input  wire cfg_t                cfg,
    output prod_vec_t                prod
);

    sample_t   win [TAPS];
    prod_vec_t prod_next;
    prod_vec_t prod_reg;
    logic [TAP_IDX_W-1:0] sel [TAPS];

    assign prod = prod_reg;

    // window position 0 is the newest sample
    always_comb begin
        win[0] = sample;
        for (int j = 1; j < TAPS; j++) begin
            win[j] = old_row[j-1];
        end
    end

    // coef k weights the sample n-1-k places back
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            sel[k] = TAP_IDX_W'(int'(n_taps) - 1 - k);
            if (k < int'(n_taps)) begin
                prod_next[k] = prod_t'(cfg.coef[k]) * prod_t'(win[sel[k]]);
            end else begin
                prod_next[k] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mcfir_sum.sv @@
// Product sum: registered half sums, then final add, rounding and saturation, or the bypass sample.
`default_nettype none

module mcfir_sum import mcfir_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      en,
    input  wire prod_vec_t prod,
    input  wire logic      bypass,
    input  wire sample_t   bypass_sample,
    output sample_t        result
);

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-32768);
    localparam acc_t                  RND   = ACC_W'(1 << (FRAC_W - 1));

    acc_t lo_next;
    acc_t hi_next;
    acc_t lo_reg;
    acc_t hi_reg;
    acc_t total;
    logic signed [Q_W-1:0] q;
    sample_t sat;

    always_comb begin
        lo_next = '0;
        hi_next = '0;
        for (int k = 0; k < TAPS; k++) begin
            if (k < HALF_TAPS) begin
                lo_next = lo_next + {{(ACC_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]};
            end else begin
                hi_next = hi_next + {{(ACC_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // round half up, then clamp to 16 bits
    always_comb begin
        total = lo_reg + hi_reg + RND;
        q     = total[ACC_W-1:FRAC_W];
        priority if (q > Q_MAX) begin
            sat = sample_t'(Q_MAX[SAMPLE_W-1:0]);
        end else if (q < Q_MIN) begin
            sat = sample_t'(Q_MIN[SAMPLE_W-1:0]);
        end else begin
            sat = sample_t'(q[SAMPLE_W-1:0]);
        end
        result = bypass ? bypass_sample : sat;
    end

endmodule

`default_nettype wire
